// ----- hw/rtl/sfvm_pkg.sv -----
// Shared types and constants for the stack-frame VM execute unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfvm_pkg;
  localparam int StackDepth = 128;
  localparam int AddrW = $clog2(StackDepth);

  localparam logic [2:0] CmdMov = 3'd0;
  localparam logic [2:0] CmdCal = 3'd1;
  localparam logic [2:0] CmdPop = 3'd2;
  localparam logic [2:0] CmdRet = 3'd3;
  localparam logic [2:0] CmdAdd = 3'd4;
  localparam logic [2:0] CmdAnd = 3'd5;
  localparam logic [2:0] CmdNot = 3'd6;
  localparam logic [2:0] CmdEqu = 3'd7;

  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StFin   = 2'd1;
  localparam logic [1:0] StOvf   = 2'd2;
  localparam logic [1:0] StUnk   = 2'd3;

  localparam logic [7:0] FrameMark = 8'd3;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OpNone,     // nothing
    OpRdIdx,    // rdata <- mem[idx], idx from sel
    OpWrIdx,    // mem[idx] <- wval
    OpLatchA,   // a <- rdata
    OpLatchB,   // b <- rdata
    OpSetFb,    // frame base <- idx value low 8 bits
    OpSetLab,   // label <- a or source operand low 4 bits, arg counter loaded
    OpRegWr,    // reg[rsel] <- wval
    OpAlu,      // register ALU op
    OpCntDec    // argument counter decrement, arg index advance
  } dp_op_e;

  // Index sources; each is a 10-bit signed sum checked for range.
  typedef enum logic [3:0] {
    IxFbPlusSo, IxFbPlusD, IxFbPlus1, IxFbPlus2, IxFbPlusA,
    IxA, IxB, IxFbM1, IxFbM2, IxFb, IxArg, IxFbPlusA1,
    IxFbPlusA2, IxFbMinusB
  } ix_sel_e;

  typedef enum logic [3:0] {
    WvA, WvB, WvSrc, WvZero, WvLabel, WvMark, WvAp1, WvPcInc, WvDp1, WvAmFb1
  } wv_sel_e;

  typedef struct packed {
    dp_op_e  op;
    ix_sel_e ix;
    wv_sel_e wv;
  } dp_cmd_t;

  typedef struct packed {
    logic       ix_bad;   // index out of range
    logic [7:0] rdata;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] src_imm_reg;
    logic [3:0] label;
    logic [3:0] arg_cnt;
    logic [7:0] fb;
  } dp_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/stack_frame_vm_execute_unit.sv -----
// Top level of the stack-frame VM execute unit: config registers, controller, datapath.
// Depends on sfvm_pkg, sfvm_controller and sfvm_datapath.
//
// An instruction is taken when start is high and busy low; its result is
// shown for one cycle with done_o high and cannot be stalled. The single-port
// stack memory sets the time: each stack read costs a read state and a latch
// state. Once halted, an instruction skips execution and only reports the
// halt status. After reset the stack is cleared at one entry per cycle with
// busy high.
`timescale 1ns / 1ps
`default_nettype none
module stack_frame_vm_execute_unit import sfvm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command_i,
  input  wire logic [1:0]  source_mode_i,
  input  wire logic [7:0]  source_operand_i,
  input  wire logic [1:0]  dest_mode_i,
  input  wire logic [6:0]  dest_operand_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             print_valid_o,
  output logic [7:0]       print_value_o,
  output logic [3:0]       next_function_o,
  output logic [7:0]       next_pc_o
);
  logic [63:0] arg_counts_q;
  logic [15:0] defined_q;
  logic        load, mem_clear;
  logic [AddrW-1:0] clr_addr;
  dp_cmd_t     dcmd;
  dp_stat_t    dstat;
  logic [3:0]  cnt_init;
  logic [3:0]  source_operand_i_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_counts_q <= 64'd0;
      defined_q <= 16'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i) defined_q <= cfg_data_i[15:0];
      else arg_counts_q <= cfg_data_i;
    end
  end

  assign cnt_init = arg_counts_q[{source_operand_i_q, 2'b00} +: 4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) source_operand_i_q <= '0;
    else if (load) source_operand_i_q <= source_operand_i[3:0];
  end

  sfvm_controller u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .command_i, .source_mode_i, .source_operand_i,
    .dest_mode_i, .dest_operand_i, .defined_i(defined_q), .stat_i(dstat),
    .busy_o(busy), .load_o(load), .mem_clear_o(mem_clear), .clr_addr_o(clr_addr),
    .cmd_o(dcmd), .done_o, .status_o, .print_valid_o, .print_value_o,
    .next_function_o, .next_pc_o
  );

  sfvm_datapath u_dp (
    .clk_i, .rst_ni, .load_i(load), .command_i, .source_operand_i, .dest_operand_i,
    .source_mode_i, .cnt_init_i(cnt_init), .mem_clear_i(mem_clear),
    .clr_addr_i(clr_addr), .cmd_i(dcmd), .stat_o(dstat)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/sfvm_datapath.sv -----
// Datapath: stack memory, registers, frame base, label and scratch registers.
// Depends on sfvm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfvm_datapath import sfvm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire logic [2:0] command_i,
  input  wire logic [7:0] source_operand_i,
  input  wire logic [6:0] dest_operand_i,
  input  wire logic [1:0] source_mode_i,
  input  wire logic [3:0] cnt_init_i,
  input  wire logic       mem_clear_i,
  input  wire logic [AddrW-1:0] clr_addr_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_stat_t        stat_o
);
  logic [7:0] mem_q [StackDepth];
  logic [7:0] regs_q [8];
  logic [7:0] rdata_q, a_q, b_q, fb_q, arg_q;
  logic [3:0] lab_q, cnt_q;
  logic [2:0] cmd_q, rs_q, rd_q;
  logic [7:0] so_q;
  logic [6:0] d_q;
  logic [1:0] sm_q;
  logic signed [9:0] idx;
  logic [AddrW-1:0] ai;
  logic [7:0] wv;

  always_comb begin
    unique case (cmd_i.ix)
      IxFbPlusSo: idx = $signed({2'b0, fb_q}) + $signed({2'b0, so_q});
      IxFbPlusD:  idx = $signed({2'b0, fb_q}) + $signed({3'b0, d_q});
      IxFbPlus1:  idx = $signed({2'b0, fb_q}) + 10'sd1;
      IxFbPlus2:  idx = $signed({2'b0, fb_q}) + 10'sd2;
      IxFbPlusA:  idx = $signed({2'b0, fb_q}) + $signed({2'b0, a_q});
      IxA:        idx = $signed({2'b0, a_q});
      IxB:        idx = $signed({2'b0, b_q});
      IxFbM1:     idx = $signed({2'b0, fb_q}) - 10'sd1;
      IxFbM2:     idx = $signed({2'b0, fb_q}) - 10'sd2;
      IxFb:       idx = $signed({2'b0, fb_q});
      IxArg:      idx = $signed({2'b0, arg_q});
      IxFbPlusA1: idx = $signed({2'b0, fb_q}) + $signed({2'b0, a_q}) + 10'sd1;
      IxFbPlusA2: idx = $signed({2'b0, fb_q}) + $signed({2'b0, a_q}) + 10'sd2;
      IxFbMinusB: idx = $signed({2'b0, fb_q}) - $signed({2'b0, b_q});
      default:    idx = '0;
    endcase
  end
  assign ai = idx[AddrW-1:0];

  always_comb begin
    unique case (cmd_i.wv)
      WvA:     wv = a_q;
      WvB:     wv = b_q;
      WvSrc:   wv = (sm_q == 2'd0) ? so_q : (sm_q == 2'd1) ? regs_q[so_q[2:0]] : rdata_q;
      WvZero:  wv = 8'd0;
      WvLabel: wv = {4'd0, lab_q};
      WvMark:  wv = FrameMark;
      WvAp1:   wv = a_q + 8'd1;
      WvPcInc: wv = rdata_q + 8'd1;
      WvDp1:   wv = {1'b0, d_q} + 8'd1;
      WvAmFb1: wv = a_q - fb_q + 8'd1;
      default: wv = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_clear_i) begin
      mem_q[clr_addr_i] <= (clr_addr_i == AddrW'(1)) ? FrameMark : 8'd0;
    end else if (cmd_i.op == OpWrIdx) begin
      mem_q[ai] <= wv;
    end
    rdata_q <= mem_q[ai];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= 8'd0;
      fb_q <= 8'd0;
      lab_q <= 4'd0;
      a_q <= 8'd0; b_q <= 8'd0; arg_q <= 8'd0; cnt_q <= 4'd0;
      cmd_q <= 3'd0; so_q <= 8'd0; d_q <= 7'd0; sm_q <= 2'd0;
      rs_q <= 3'd0; rd_q <= 3'd0;
    end else begin
      if (load_i) begin
        cmd_q <= command_i; so_q <= source_operand_i; d_q <= dest_operand_i;
        sm_q <= source_mode_i; rs_q <= source_operand_i[2:0];
        rd_q <= dest_operand_i[2:0]; arg_q <= {1'b0, dest_operand_i};
      end
      unique case (cmd_i.op)
        OpLatchA: a_q <= rdata_q;
        OpLatchB: b_q <= rdata_q;
        OpSetFb:  fb_q <= idx[7:0];
        OpSetLab: begin
          lab_q <= (cmd_i.wv == WvA) ? a_q[3:0] : so_q[3:0];
          cnt_q <= cnt_init_i;
        end
        OpRegWr:  regs_q[rd_q] <= wv;
        OpAlu: begin
          case (cmd_q)
            CmdAdd:  regs_q[rs_q] <= regs_q[rs_q] + regs_q[rd_q];
            CmdAnd:  regs_q[rs_q] <= regs_q[rs_q] & regs_q[rd_q];
            CmdNot:  regs_q[rs_q] <= ~regs_q[rs_q];
            default: regs_q[rs_q] <= (regs_q[rs_q] == 8'd0) ? 8'd1 : 8'd0;
          endcase
        end
        OpCntDec: begin
          cnt_q <= cnt_q - 4'd1;
          arg_q <= arg_q + 8'd1;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.ix_bad      = (idx < 0) || (idx >= StackDepth);
  assign stat_o.rdata       = rdata_q;
  assign stat_o.a           = a_q;
  assign stat_o.b           = b_q;
  assign stat_o.src_imm_reg = (sm_q == 2'd0) ? so_q : regs_q[so_q[2:0]];
  assign stat_o.label       = lab_q;
  assign stat_o.arg_cnt     = cnt_q;
  assign stat_o.fb          = fb_q;
endmodule
`default_nettype wire

// ----- hw/rtl/sfvm_controller.sv -----
// Controller: sequences memory accesses of each instruction, halt and status.
// Depends on sfvm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfvm_controller import sfvm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [2:0]  command_i,
  input  wire logic [1:0]  source_mode_i,
  input  wire logic [7:0]  source_operand_i,
  input  wire logic [1:0]  dest_mode_i,
  input  wire logic [6:0]  dest_operand_i,
  input  wire logic [15:0] defined_i,
  input  dp_stat_t         stat_i,
  output logic             busy_o,
  output logic             load_o,
  output logic             mem_clear_o,
  output logic [AddrW-1:0] clr_addr_o,
  output dp_cmd_t          cmd_o,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic             print_valid_o,
  output logic [7:0]       print_value_o,
  output logic [3:0]       next_function_o,
  output logic [7:0]       next_pc_o
);
  typedef enum logic [5:0] {
    SClr, SIdle, SDisp,
    SSrcRd, SSrcW, SSrcPtr, SSrcPtrW, SSrcDone,
    SDstPtrRd, SDstPtrW, SMovWr, SSpRd, SSpW, SSpWr,
    SPopRd, SPopW, SPopWr,
    SRetRd1, SRetW1, SRetRd2, SRetW2, SRetFb, SRetLab,
    SPushSp, SPushSpW, SPushWr, SPushInc, SCalBase, SCalW0, SCalW2,
    SCalLab, SCalSetLab, SArgRd, SArgW, SArgSp, SArgSpW,
    SPcRd, SPcW, SNpcRd, SNpcW, SDone
  } state_e;

  // What the shared push sequence writes.
  localparam logic [1:0] PushSlot  = 2'd0;
  localparam logic [1:0] PushLabel = 2'd1;
  localparam logic [1:0] PushArg   = 2'd2;

  state_e state_q, state_d;
  logic [AddrW:0] clr_q, clr_d;
  logic [2:0] cmd_q, cmd_d;
  logic [1:0] sm_q, sm_d, dm_q, dm_d;
  logic [6:0] d_q, d_dd;
  logic [7:0] so_q, so_d, pv_q, pv_d;
  logic [1:0] idx_q, idx_d, push_q, push_d;
  logic pvld_q, pvld_d;
  logic [1:0] halt_q, halt_d;
  logic done_d, ovf;
  logic [1:0] st_d;
  logic pvo_d; logic [7:0] pvl_d; logic [3:0] nf_d; logic [7:0] np_d;
  logic [1:0] st_q; logic pvo_q; logic [7:0] pvl_q; logic [3:0] nf_q; logic [7:0] np_q;
  logic done_q;

  function automatic logic known(input logic [7:0] lab, input logic [15:0] def);
    known = (lab < 8'd16) && def[lab[3:0]];
  endfunction

  assign ovf = stat_i.ix_bad;

  always_comb begin
    state_d = state_q; clr_d = clr_q;
    cmd_d = cmd_q; sm_d = sm_q; dm_d = dm_q; d_dd = d_q; so_d = so_q;
    pv_d = pv_q; pvld_d = pvld_q; halt_d = halt_q; idx_d = idx_q;
    push_d = push_q;
    cmd_o = '{op: OpNone, ix: IxFb, wv: WvZero};
    load_o = 1'b0; mem_clear_o = 1'b0;
    done_d = 1'b0; st_d = st_q; pvo_d = pvo_q; pvl_d = pvl_q; nf_d = nf_q; np_d = np_q;
    unique case (state_q)
      SClr: begin
        mem_clear_o = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(StackDepth - 1)) state_d = SIdle;
      end
      SIdle: if (start_i) begin
        load_o = 1'b1;
        cmd_d = command_i; sm_d = source_mode_i; dm_d = dest_mode_i;
        d_dd = dest_operand_i; so_d = source_operand_i; pvld_d = 1'b0; pv_d = 8'd0;
        idx_d = 2'd0; push_d = PushSlot;
        state_d = (halt_q != StRun) ? SDone : SDisp;
      end
      SDisp: begin
        if (!known({4'd0, stat_i.label}, defined_i)) begin
          halt_d = StUnk; state_d = SDone;
        end else begin
          case (cmd_q)
            CmdMov: begin
              if (dm_q == 2'd0) state_d = SPcRd;
              else if (dm_q == 2'd3) state_d = SDstPtrRd;
              else begin
                if (dm_q == 2'd2) begin
                  cmd_o.ix = IxFbPlusD;
                  if (ovf) begin halt_d = StOvf; state_d = SDone; end
                  else state_d = SSrcRd;
                end else state_d = SSrcRd;
              end
            end
            CmdCal: state_d = SPushSp;
            CmdPop: state_d = SPopRd;
            CmdRet: begin
              if (stat_i.label == 4'd0) begin halt_d = StFin; state_d = SDone; end
              else state_d = SRetRd1;
            end
            default: begin cmd_o.op = OpAlu; state_d = SPcRd; end
          endcase
        end
      end
      // Destination pointer: a <- mem[fb+d], checked below depth.
      SDstPtrRd: begin
        cmd_o = '{op: OpRdIdx, ix: IxFbPlusD, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SDstPtrW;
      end
      SDstPtrW: begin
        cmd_o.op = OpLatchA;
        if (stat_i.rdata >= 8'(StackDepth)) begin halt_d = StOvf; state_d = SDone; end
        else state_d = SSrcRd;
      end
      // Source fetch; for memory modes b ends up holding the value.
      SSrcRd: begin
        if (sm_q[1]) begin
          cmd_o = '{op: OpRdIdx, ix: IxFbPlusSo, wv: WvZero};
          if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SSrcW;
        end else state_d = SSrcDone;
      end
      SSrcW: begin
        cmd_o.op = OpLatchB;
        state_d = sm_q[0] ? SSrcPtr : SSrcDone;
      end
      SSrcPtr: begin
        cmd_o = '{op: OpRdIdx, ix: IxB, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SSrcPtrW;
      end
      SSrcPtrW: begin cmd_o.op = OpLatchB; state_d = SSrcDone; end
      SSrcDone: begin
        if (!sm_q[1]) pv_d = stat_i.src_imm_reg; else pv_d = stat_i.b;
        state_d = SMovWr;
      end
      SMovWr: begin
        if (dm_q == 2'd1) begin
          cmd_o = '{op: OpRegWr, ix: IxFb, wv: sm_q[1] ? WvB : WvSrc};
          state_d = SPcRd;
        end else begin
          cmd_o = '{op: OpWrIdx, ix: (dm_q == 2'd2) ? IxFbPlusD : IxA,
                    wv: sm_q[1] ? WvB : WvSrc};
          state_d = SSpRd;
        end
      end
      SSpRd: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlus1, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SSpW; end
      // Grow the stack pointer when the write landed at or past it.
      SSpW: begin
        if (dm_q == 2'd2) begin
          state_d = ({1'b0, d_q} >= stat_i.rdata) ? SSpWr : SPcRd;
        end else begin
          if ({1'b0, stat_i.a} >= {1'b0, stat_i.fb} + {1'b0, stat_i.rdata}) state_d = SSpWr;
          else state_d = SPcRd;
        end
      end
      SSpWr: begin
        cmd_o = '{op: OpWrIdx, ix: IxFbPlus1, wv: (dm_q == 2'd2) ? WvDp1 : WvAmFb1};
        state_d = SPcRd;
      end
      SPopRd: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlusSo, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SPopW; end
      SPopW: begin
        cmd_o.op = OpLatchA;
        if (stat_i.label == 4'd0) begin
          pvld_d = 1'b1; pv_d = stat_i.rdata; state_d = SPcRd;
        end else state_d = SPopWr;
      end
      SPopWr: begin cmd_o = '{op: OpWrIdx, ix: IxFbM2, wv: WvA};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SPcRd; end
      // RET: a <- caller label, b <- back offset.
      SRetRd1: begin cmd_o = '{op: OpRdIdx, ix: IxFbM1, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SRetW1; end
      SRetW1: begin cmd_o.op = OpLatchA; state_d = SRetRd2; end
      SRetRd2: begin cmd_o = '{op: OpRdIdx, ix: IxFb, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SRetW2; end
      SRetW2: begin cmd_o.op = OpLatchB; state_d = SRetFb; end
      SRetFb: begin
        cmd_o = '{op: OpSetFb, ix: IxFbMinusB, wv: WvZero};
        if (!known(stat_i.a, defined_i)) begin halt_d = StUnk; state_d = SDone; end
        else state_d = SRetLab;
      end
      SRetLab: begin cmd_o = '{op: OpSetLab, ix: IxFb, wv: WvA}; state_d = SPcRd; end
      // Push: return slot, label, then each argument byte.
      SPushSp: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlus1, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SPushSpW; end
      SPushSpW: begin cmd_o.op = OpLatchA; state_d = SPushWr; end
      SPushWr: begin
        cmd_o = '{op: OpWrIdx, ix: IxFbPlusA,
                  wv: (push_q == PushArg) ? WvB : (push_q == PushLabel) ? WvLabel : WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SPushInc;
      end
      SPushInc: begin
        cmd_o = '{op: OpWrIdx, ix: IxFbPlus1, wv: WvAp1};
        if (push_q == PushArg) state_d = SArgRd;
        else if (push_q == PushLabel) state_d = SCalBase;
        else begin push_d = PushLabel; state_d = SPushSp; end
      end
      SCalBase: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlus1, wv: WvZero}; state_d = SCalW0; end
      SCalW0: begin cmd_o.op = OpLatchA; state_d = SCalW2; end
      // New frame at fb+sp: back offset, stack pointer mark, pc.
      SCalW2: begin
        unique case (idx_q)
          2'd0: cmd_o = '{op: OpWrIdx, ix: IxFbPlusA, wv: WvA};
          2'd1: cmd_o = '{op: OpWrIdx, ix: IxFbPlusA1, wv: WvMark};
          default: cmd_o = '{op: OpWrIdx, ix: IxFbPlusA2, wv: WvZero};
        endcase
        if (ovf) begin halt_d = StOvf; state_d = SDone; end
        else if (idx_q == 2'd2) state_d = SCalLab;
        else idx_d = idx_q + 2'd1;
      end
      SCalLab: begin
        cmd_o = '{op: OpSetFb, ix: IxFbPlusA, wv: WvZero};
        if (!known(so_q, defined_i)) begin halt_d = StUnk; state_d = SDone; end
        else state_d = SCalSetLab;
      end
      SCalSetLab: begin
        cmd_o = '{op: OpSetLab, ix: IxFb, wv: WvZero};
        push_d = PushArg; state_d = SArgRd;
      end
      SArgRd: begin
        if (stat_i.arg_cnt == 4'd0) state_d = SNpcRd;
        else begin
          cmd_o = '{op: OpRdIdx, ix: IxArg, wv: WvZero};
          if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SArgW;
        end
      end
      SArgW: begin cmd_o.op = OpLatchB; state_d = SArgSp; end
      SArgSp: begin cmd_o = '{op: OpCntDec, ix: IxFbPlus1, wv: WvZero}; state_d = SArgSpW; end
      SArgSpW: begin cmd_o.op = OpLatchA; state_d = SPushWr; end
      SPcRd: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlus2, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SPcW; end
      SPcW: begin cmd_o = '{op: OpWrIdx, ix: IxFbPlus2, wv: WvPcInc}; state_d = SNpcRd; end
      SNpcRd: begin cmd_o = '{op: OpRdIdx, ix: IxFbPlus2, wv: WvZero};
        if (ovf) begin halt_d = StOvf; state_d = SDone; end else state_d = SNpcW; end
      SNpcW: begin
        done_d = 1'b1; st_d = StRun; pvo_d = pvld_q; pvl_d = pvld_q ? pv_q : 8'd0;
        nf_d = stat_i.label; np_d = stat_i.rdata; state_d = SIdle;
      end
      SDone: begin
        done_d = 1'b1; st_d = halt_q; pvo_d = 1'b0; pvl_d = 8'd0; nf_d = 4'd0; np_d = 8'd0;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr; clr_q <= '0;
      cmd_q <= '0; sm_q <= '0; dm_q <= '0; d_q <= '0; so_q <= '0;
      pv_q <= '0; pvld_q <= 1'b0; halt_q <= StRun; idx_q <= '0; push_q <= PushSlot;
      done_q <= 1'b0; st_q <= '0; pvo_q <= 1'b0; pvl_q <= '0; nf_q <= '0; np_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d;
      cmd_q <= cmd_d; sm_q <= sm_d; dm_q <= dm_d; d_q <= d_dd; so_q <= so_d;
      pv_q <= pv_d; pvld_q <= pvld_d; halt_q <= halt_d; idx_q <= idx_d;
      push_q <= push_d;
      done_q <= done_d; st_q <= st_d; pvo_q <= pvo_d; pvl_q <= pvl_d;
      nf_q <= nf_d; np_q <= np_d;
    end
  end

  assign busy_o = (state_q != SIdle);
  assign clr_addr_o = clr_q[AddrW-1:0];
  assign done_o = done_q;
  assign status_o = st_q;
  assign print_valid_o = pvo_q;
  assign print_value_o = pvl_q;
  assign next_function_o = nf_q;
  assign next_pc_o = np_q;
endmodule
`default_nettype wire

// ----- hw/rtl/sfvm_checker.sv -----
// Port-level checks for the execute unit, bound to the top level.
// Imports no package; the bind below refers to stack_frame_vm_execute_unit.
`timescale 1ns / 1ps
`default_nettype none
module sfvm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done_o,
  input wire logic [1:0] status_o,
  input wire logic       print_valid_o,
  input wire logic [7:0] print_value_o,
  input wire logic [3:0] next_function_o,
  input wire logic [7:0] next_pc_o
);
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("item taken without busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without work");
  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !print_valid_o |-> print_value_o == 8'd0) else $error("stray print value");
  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != 2'd0 |-> next_pc_o == 8'd0 && next_function_o == 4'd0)
    else $error("halt fields not cleared");
endmodule

bind stack_frame_vm_execute_unit sfvm_checker u_chk (.*);
`default_nettype wire
